FILE: sv/cuckoo_hash_set_unit_assert.svh
`ifndef CUCKOO_HASH_SET_UNIT_ASSERT_SVH
`define CUCKOO_HASH_SET_UNIT_ASSERT_SVH
// implication checked every cycle outside reset
`define CHS_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define CHS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: sv/chs_pkg.sv
`timescale 1ns / 1ps
package chs_pkg;
   localparam int TableDepthDefault = 1024;
   localparam int MaxKicksDefault = 32;
   localparam int KeyW = 64;
   localparam int CountW = 12;
   localparam int CapW = 4;
   localparam int WordAw = 11;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_LOAD = 2'd3;

   localparam logic [2:0] ST_DONE = 3'd0;
   localparam logic [2:0] ST_PRESENT = 3'd1;
   localparam logic [2:0] ST_MISSING = 3'd2;
   localparam logic [2:0] ST_ZERO = 3'd3;
   localparam logic [2:0] ST_KICKS = 3'd4;
   localparam logic [2:0] ST_LOADED = 3'd5;

   typedef struct packed {
      logic [1:0] func;
      logic [63:0] key;
      logic hash_select;
      logic [2:0] byte_position;
      logic [7:0] byte_value;
      logic [63:0] hash_word;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic found;
      logic [63:0] homeless_key;
      logic [11:0] element_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic load_word;
      logic hash_step;
      logic slot_read;
      logic remove_one;
      logic remove_two;
      logic place_one;
      logic place_two;
      logic evict_one;
      logic count_up;
      logic count_down;
      logic finish;
      logic [2:0] status;
      logic found;
      logic homeless;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic key_zero;
      logic hash_last;
      logic in_one;
      logic in_two;
      logic empty_one;
      logic empty_two;
      logic kicks_left;
      logic clearing;
   } stat_type;
endpackage

FILE: sv/chs_datapath.sv
`timescale 1ns / 1ps
module chs_datapath
   import chs_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int MAX_KICKS = MaxKicksDefault
) (
   input logic clock,
   input logic reset,
   input req_type req_data,
   input logic csr_write,
   input logic [CapW-1:0] csr_data,
   input cmd_type cmd,
   output stat_type stat,
   output rsp_type rsp_data
);
   localparam int SlotAw = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KickW = $clog2(MAX_KICKS + 1);
   localparam int ClearW = SlotAw + 1;

   logic [KeyW-1:0] words_one [2**WordAw];
   logic [KeyW-1:0] words_two [2**WordAw];
   logic [KeyW-1:0] slots_one [TABLE_DEPTH];
   logic [KeyW-1:0] slots_two [TABLE_DEPTH];

   req_type req_ff;
   logic [KeyW-1:0] cur_ff, cur_in;
   logic [CapW-1:0] cap_ff;
   logic [2:0] byte_ff;
   logic [KeyW-1:0] acc1_ff, acc2_ff;
   logic [KeyW-1:0] w1_ff, w2_ff;
   logic wvalid_ff;
   logic [SlotAw-1:0] h1_ff, h2_ff;
   logic [KeyW-1:0] s1_ff, s2_ff;
   logic [KickW-1:0] kicks_ff;
   logic [CountW-1:0] count_ff;
   logic [ClearW-1:0] clear_ff;
   rsp_type rsp_ff;

   logic [WordAw-1:0] rd_addr;
   logic [KeyW-1:0] fin1, fin2, mask;
   logic [SlotAw-1:0] idx1, idx2;
   logic [KeyW-1:0] slot1, slot2;
   logic clear_busy;

   assign rd_addr = {byte_ff, cur_ff[8*byte_ff +: 8]};
   assign fin1 = acc1_ff ^ (wvalid_ff ? w1_ff : '0);
   assign fin2 = acc2_ff ^ (wvalid_ff ? w2_ff : '0);
   assign mask = ({{(KeyW-1){1'b0}}, 1'b1} << cap_ff) - {{(KeyW-1){1'b0}}, 1'b1};
   assign idx1 = SlotAw'(64'(fin1 & mask) % 64'(TABLE_DEPTH));
   assign idx2 = SlotAw'(64'(fin2 & mask) % 64'(TABLE_DEPTH));
   assign slot1 = s1_ff;
   assign slot2 = s2_ff;
   assign clear_busy = clear_ff != ClearW'(TABLE_DEPTH);

   always_comb begin
      cur_in = cur_ff;
      if (cmd.take_req) cur_in = req_data.key;
      else if (cmd.evict_one) cur_in = slot1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         if (req_ff.hash_select)
            words_two[{req_ff.byte_position, req_ff.byte_value}] <= req_ff.hash_word;
         else
            words_one[{req_ff.byte_position, req_ff.byte_value}] <= req_ff.hash_word;
      end
      w1_ff <= words_one[rd_addr];
      w2_ff <= words_two[rd_addr];
      if (cmd.slot_read) begin
         s1_ff <= slots_one[idx1];
         s2_ff <= slots_two[idx2];
         h1_ff <= idx1;
         h2_ff <= idx2;
      end
      if (clear_busy) begin
         slots_one[clear_ff[SlotAw-1:0]] <= '0;
         slots_two[clear_ff[SlotAw-1:0]] <= '0;
      end else begin
         if (cmd.remove_one) slots_one[h1_ff] <= '0;
         else if (cmd.place_one || cmd.evict_one) slots_one[h1_ff] <= cur_ff;
         if (cmd.remove_two) slots_two[h2_ff] <= '0;
         else if (cmd.place_two) slots_two[h2_ff] <= cur_ff;
      end
      if (cmd.take_req) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapW'(10);
         clear_ff <= '0;
         count_ff <= '0;
         byte_ff <= '0;
         wvalid_ff <= 1'b0;
         kicks_ff <= '0;
      end else begin
         if (csr_write) cap_ff <= csr_data;
         if (clear_busy) clear_ff <= clear_ff + 1'b1;
         cur_ff <= cur_in;
         if (cmd.take_req) kicks_ff <= '0;
         if (cmd.evict_one) kicks_ff <= kicks_ff + 1'b1;
         // hash walks one key byte per cycle, word read registered
         if (cmd.hash_step) begin
            byte_ff <= byte_ff + 3'd1;
            wvalid_ff <= 1'b1;
            acc1_ff <= fin1;
            acc2_ff <= fin2;
         end else begin
            byte_ff <= '0;
            wvalid_ff <= 1'b0;
            acc1_ff <= '0;
            acc2_ff <= '0;
         end
         if (cmd.count_up) count_ff <= count_ff + 1'b1;
         if (cmd.count_down && count_ff != '0) count_ff <= count_ff - 1'b1;
         if (cmd.finish) begin
            rsp_ff.status <= cmd.status;
            rsp_ff.found <= cmd.found;
            rsp_ff.homeless_key <= cmd.homeless ? cur_in : '0;
            rsp_ff.element_count <= count_ff + (cmd.count_up ? 12'd1 : 12'd0)
               - ((cmd.count_down && count_ff != '0) ? 12'd1 : 12'd0);
         end
      end
   end

   assign stat.func = req_ff.func;
   assign stat.key_zero = req_ff.key == '0;
   assign stat.hash_last = byte_ff == 3'd0 && wvalid_ff;
   assign stat.in_one = slot1 == cur_ff;
   assign stat.in_two = slot2 == cur_ff;
   assign stat.empty_one = slot1 == '0;
   assign stat.empty_two = slot2 == '0;
   assign stat.kicks_left = kicks_ff < KickW'(MAX_KICKS - 1);
   assign stat.clearing = clear_busy;
   assign rsp_data = rsp_ff;
endmodule

FILE: sv/chs_control.sv
`timescale 1ns / 1ps
module chs_control
   import chs_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   input stat_type stat,
   output cmd_type cmd
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HASH = 5'b00010,
      S_READ = 5'b00100,
      S_DECIDE = 5'b01000,
      S_WAIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic insert_ff, insert_in;

   assign req_stall = state_ff != S_IDLE || stat.clearing || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      insert_in = insert_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.take_req = 1'b1;
               state_in = S_WAIT;
               insert_in = 1'b0;
            end
         end
         S_WAIT: begin
            if (stat.func == FUNC_LOAD) begin
               cmd.load_word = 1'b1;
               cmd.finish = 1'b1;
               cmd.status = ST_LOADED;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (stat.key_zero) begin
               cmd.finish = 1'b1;
               cmd.status = ST_ZERO;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.hash_step = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = !stat.hash_last;
            if (stat.hash_last) begin
               cmd.slot_read = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            cmd.finish = 1'b1;
            if (insert_ff) begin
               if (stat.empty_one) begin
                  cmd.place_one = 1'b1; cmd.count_up = 1'b1; cmd.status = ST_DONE;
               end else if (stat.empty_two) begin
                  cmd.place_two = 1'b1; cmd.count_up = 1'b1; cmd.status = ST_DONE;
               end else begin
                  cmd.evict_one = 1'b1;
                  if (stat.kicks_left) begin
                     cmd.finish = 1'b0; rsp_valid_in = 1'b0;
                     state_in = S_HASH;
                  end else begin
                     cmd.status = ST_KICKS;
                     cmd.homeless = 1'b1;
                     insert_in = 1'b0;
                  end
               end
            end else if (stat.func == FUNC_LOOKUP) begin
               cmd.found = stat.in_one || stat.in_two;
               cmd.status = cmd.found ? ST_DONE : ST_MISSING;
            end else if (stat.func == FUNC_REMOVE) begin
               if (stat.in_one || stat.in_two) begin
                  cmd.remove_one = stat.in_one;
                  cmd.remove_two = !stat.in_one;
                  cmd.count_down = 1'b1;
                  cmd.status = ST_DONE;
               end else cmd.status = ST_MISSING;
            end else if (stat.in_one || stat.in_two) begin
               cmd.status = ST_PRESENT;
            end else begin
               cmd.finish = 1'b0; rsp_valid_in = 1'b0;
               insert_in = 1'b1;
               state_in = S_DECIDE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         insert_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         insert_ff <= insert_in;
      end
   end
endmodule

FILE: sv/cuckoo_hash_set_unit.sv
`timescale 1ns / 1ps
// Cuckoo hash set of nonzero 64-bit keys in two tables addressed by tabulation hashes. After
// reset a clearing pass empties the slot tables one slot at a time while req_stall is high.
// One transaction at a time: load and zero-key transactions finish in the wait state, lookup,
// remove and present-key insert walk one key byte per cycle through the hash word memories,
// then do a slot read and decide; an insert of a new key takes a second decide step, and each
// eviction round repeats the hash and slot read. A stalled result holds off the next request.
`include "cuckoo_hash_set_unit_assert.svh"
module cuckoo_hash_set_unit
   import chs_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int MAX_KICKS = MaxKicksDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_write,
   input logic [CapW-1:0] csr_data
);
   cmd_type cmd;
   stat_type stat;

   chs_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .cmd(cmd)
   );

   chs_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_KICKS(MAX_KICKS)) u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .csr_write(csr_write),
      .csr_data(csr_data), .cmd(cmd), .stat(stat), .rsp_data(rsp_data)
   );

   `CHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CHS_ASSERT_IMPL(a_one_write, clock, reset, cmd.place_one, !cmd.place_two && !cmd.remove_one)
   `CHS_ASSERT_IMPL(a_finish_rsp, clock, reset, cmd.take_req, !rsp_valid || !rsp_stall)
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import chs_pkg::*;

   localparam int SlotDepth = 1024;
   localparam int KickRounds = 32;
   localparam int CycleLimit = 4000000;

   typedef struct {
      req_type req;
      bit typed;
      rsp_type rsp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CapW-1:0] csr_data = '0;

   logic [63:0] hash_words [2][2048];
   logic [63:0] slots_a [SlotDepth];
   logic [63:0] slots_b [SlotDepth];
   logic [11:0] key_total;
   logic [3:0] cap_bits;

   rsp_type pending_rsp [$];
   row_type rows [$];
   logic [63:0] key_pool [256];
   int pool_size;
   int fails = 0;
   int cycles = 0;
   bit calm = 1'b0;

   cuckoo_hash_set_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int slot_of(int sel, logic [63:0] k);
      logic [63:0] acc;
      logic [63:0] mask;
      acc = '0;
      for (int b = 0; b < 8; b++) acc ^= hash_words[sel][b * 256 + k[8 * b +: 8]];
      mask = (64'd1 << cap_bits) - 64'd1;
      return int'((acc & mask) % SlotDepth);
   endfunction

   function automatic rsp_type model_item(req_type r);
      rsp_type o;
      int h1, h2, a, c;
      bit in1, in2, placed;
      logic [63:0] cur, out_key;
      o = '0;
      o.status = ST_DONE;
      if (r.func == FUNC_LOAD) begin
         hash_words[r.hash_select][{r.byte_position, r.byte_value}] = r.hash_word;
         o.status = ST_LOADED;
      end else if (r.key == '0) begin
         o.status = ST_ZERO;
      end else begin
         h1 = slot_of(0, r.key);
         h2 = slot_of(1, r.key);
         in1 = slots_a[h1] == r.key;
         in2 = slots_b[h2] == r.key;
         if (r.func == FUNC_LOOKUP) begin
            o.found = in1 || in2;
            o.status = o.found ? ST_DONE : ST_MISSING;
         end else if (r.func == FUNC_REMOVE) begin
            if (in1 || in2) begin
               if (in1) slots_a[h1] = '0;
               else slots_b[h2] = '0;
               if (key_total != 12'd0) key_total = key_total - 12'd1;
            end else begin
               o.status = ST_MISSING;
            end
         end else if (in1 || in2) begin
            o.status = ST_PRESENT;
         end else begin
            cur = r.key;
            placed = 1'b0;
            for (int n = 0; n < KickRounds && !placed; n++) begin
               a = slot_of(0, cur);
               c = slot_of(1, cur);
               if (slots_a[a] == '0) begin
                  slots_a[a] = cur;
                  placed = 1'b1;
               end else if (slots_b[c] == '0) begin
                  slots_b[c] = cur;
                  placed = 1'b1;
               end else begin
                  out_key = slots_a[a];
                  slots_a[a] = cur;
                  cur = out_key;
               end
            end
            if (placed) key_total = key_total + 12'd1;
            else begin
               o.homeless_key = cur;
               o.status = ST_KICKS;
            end
         end
      end
      o.element_count = key_total;
      return o;
   endfunction

   task automatic send(req_type r, bit typed, rsp_type want);
      rsp_type got;
      if (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = model_item(r);
      pending_rsp = {pending_rsp, (typed ? want : got)};
   endtask

   task automatic set_capacity(logic [3:0] v);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      cap_bits = v;
   endtask

   function automatic req_type op(logic [1:0] f, logic [63:0] k);
      req_type r;
      r = '0;
      r.func = f;
      r.key = k;
      r.hash_select = 1'($urandom_range(1));
      r.byte_position = 3'($urandom_range(7));
      r.byte_value = 8'($urandom_range(255));
      r.hash_word = {$urandom, $urandom};
      return r;
   endfunction

   task automatic add_row(req_type r, bit typed, logic [2:0] st);
      row_type w;
      w.req = r;
      w.typed = typed;
      w.rsp = '0;
      w.rsp.status = st;
      rows.push_front(w);
      rows = rows.reverse() == rows.reverse() ? rows : rows;
   endtask

   // key bytes come from eight values whose hash words are all loaded
   function automatic logic [7:0] key_byte(int j);
      logic [2:0] t;
      t = 3'(j);
      return {t[2], {6{t[1]}}, t[0]};
   endfunction

   function automatic logic [63:0] nonzero_key();
      logic [63:0] k;
      for (int b = 0; b < 8; b++) k[8 * b +: 8] = key_byte($urandom_range(7));
      if (k == '0) k = 64'd1;
      return k;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected transaction on result channel");
            fails++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               fails++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found expected %0d actual %0d", want.found, rsp_data.found);
               fails++;
            end
            if (rsp_data.homeless_key !== want.homeless_key) begin
               $error("homeless_key expected %h actual %h", want.homeless_key,
                  rsp_data.homeless_key);
               fails++;
            end
            if (rsp_data.element_count !== want.element_count) begin
               $error("element_count expected %0d actual %0d", want.element_count,
                  rsp_data.element_count);
               fails++;
            end
         end
      end
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
   end

   initial begin
      req_type r;
      rsp_type none;
      logic [3:0] caps [8];
      int pick;
      caps = '{4'd10, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd11, 4'd2};
      none = '0;
      for (int i = 0; i < 2048; i++) begin
         hash_words[0][i] = '0;
         hash_words[1][i] = '0;
      end
      for (int i = 0; i < SlotDepth; i++) begin
         slots_a[i] = '0;
         slots_b[i] = '0;
      end
      key_total = '0;
      cap_bits = 4'd10;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(op(FUNC_INSERT, '0), 1'b1, ST_ZERO);
      add_row(op(FUNC_LOOKUP, '0), 1'b1, ST_ZERO);
      add_row(op(FUNC_REMOVE, '0), 1'b1, ST_ZERO);
      r = op(FUNC_LOAD, '1);
      r.hash_select = 1'b1; r.byte_position = 3'd7; r.byte_value = 8'hff; r.hash_word = '1;
      add_row(r, 1'b1, ST_LOADED);
      r = op(FUNC_LOAD, '0);
      r.hash_select = 1'b0; r.byte_position = 3'd0; r.byte_value = 8'h00; r.hash_word = '0;
      add_row(r, 1'b1, ST_LOADED);
      foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].rsp);
      rows.delete();

      for (int s = 0; s < 2; s++) begin
         for (int b = 0; b < 8; b++) begin
            for (int j = 0; j < 8; j++) begin
               r = op(FUNC_LOAD, {$urandom, $urandom});
               r.hash_select = 1'(s);
               r.byte_position = 3'(b);
               r.byte_value = key_byte(j);
               send(r, 1'b0, none);
            end
         end
      end

      add_row(op(FUNC_INSERT, '1), 1'b0, ST_DONE);
      add_row(op(FUNC_LOOKUP, '1), 1'b0, ST_DONE);
      add_row(op(FUNC_INSERT, '1), 1'b0, ST_DONE);
      add_row(op(FUNC_REMOVE, '1), 1'b0, ST_DONE);
      add_row(op(FUNC_REMOVE, '1), 1'b0, ST_DONE);
      add_row(op(FUNC_LOOKUP, '1), 1'b0, ST_DONE);
      add_row(op(FUNC_INSERT, 64'd1), 1'b0, ST_DONE);
      add_row(op(FUNC_INSERT, 64'h8000_0000_0000_0000), 1'b0, ST_DONE);
      add_row(op(FUNC_LOOKUP, 64'd1), 1'b0, ST_DONE);
      add_row(op(FUNC_LOOKUP, 64'h8000_0000_0000_0000), 1'b0, ST_DONE);
      add_row(op(FUNC_REMOVE, 64'd1), 1'b0, ST_DONE);
      foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].rsp);

      for (int p = 0; p < 8; p++) begin
         set_capacity(caps[p]);
         calm = (p == 1);
         pool_size = (caps[p] < 4) ? 8 : 200;
         for (int i = 0; i < pool_size; i++) key_pool[i] = nonzero_key();
         for (int i = 0; i < 125; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) r = op(FUNC_INSERT, key_pool[$urandom_range(pool_size - 1)]);
            else if (pick < 65) r = op(FUNC_LOOKUP, key_pool[$urandom_range(pool_size - 1)]);
            else if (pick < 88) r = op(FUNC_REMOVE, key_pool[$urandom_range(pool_size - 1)]);
            else if (pick < 93) r = op(FUNC_LOAD, nonzero_key());
            else if (pick < 96) r = op(2'($urandom_range(2)), '0);
            else r = op(2'($urandom_range(2)), nonzero_key());
            send(r, 1'b0, none);
         end
         calm = 1'b0;
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fails == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

FILE: files.f
+incdir+sv
sv/chs_pkg.sv
sv/chs_datapath.sv
sv/chs_control.sv
sv/cuckoo_hash_set_unit.sv
tb/testbench.sv
